// ===== hw/rtl/bdeq_pkg.sv =====
`default_nettype none
package bdeq_pkg;

    localparam int DEPTH = 64;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [2:0] OP_POP_FRONT  = 3'd2;
    localparam logic [2:0] OP_POP_BACK   = 3'd3;
    localparam logic [2:0] OP_READ_ALL   = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;

    // chain commands, broadcast to every cell
    localparam logic [2:0] CMD_HOLD    = 3'd0;
    localparam logic [2:0] CMD_SHIFT_R = 3'd1;
    localparam logic [2:0] CMD_APPEND  = 3'd2;
    localparam logic [2:0] CMD_SHIFT_L = 3'd3;
    localparam logic [2:0] CMD_ROTATE  = 3'd4;

    typedef struct packed {
        logic [2:0]         op;
        logic signed [31:0] value;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] data;
        logic               last;
    } out_beat_t;

    typedef struct packed {
        logic [2:0]         cmd;
        logic signed [31:0] value;
    } chain_ctl_t;

endpackage
`default_nettype wire

// ===== hw/rtl/bdeq_cell.sv =====
`default_nettype none
module bdeq_cell (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire bdeq_pkg::chain_ctl_t ctl,
    input  wire logic signed [31:0]  left_data,
    input  wire logic                left_occ,
    input  wire logic signed [31:0]  right_data,
    input  wire logic                right_occ,
    input  wire logic signed [31:0]  head_data,
    output logic signed [31:0]       data_out,
    output logic                     occ_out
);

    logic signed [31:0] data_reg;
    logic signed [31:0] data_next;
    logic               occ_reg;
    logic               occ_next;
    logic               is_tail;

    assign is_tail = occ_reg && !right_occ;

    always_comb begin
        data_next = data_reg;
        occ_next  = occ_reg;
        unique case (ctl.cmd)
            bdeq_pkg::CMD_SHIFT_R: begin
                data_next = left_data;
                occ_next  = left_occ;
            end
            bdeq_pkg::CMD_APPEND: begin
                // first free cell behind the occupied run takes the beat
                if (!occ_reg && left_occ) begin
                    data_next = ctl.value;
                    occ_next  = 1'b1;
                end
            end
            bdeq_pkg::CMD_SHIFT_L: begin
                data_next = right_data;
                occ_next  = right_occ;
            end
            bdeq_pkg::CMD_ROTATE: begin
                // head wraps around into the tail cell
                data_next = is_tail ? head_data : right_data;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= 1'b0;
        end else begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data_out = data_reg;
    assign occ_out  = occ_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/bdeq_ctrl.sv =====
`default_nettype none
module bdeq_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire bdeq_pkg::in_beat_t   s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output bdeq_pkg::out_beat_t       m_data,
    output bdeq_pkg::chain_ctl_t      ctl,
    input  wire logic signed [31:0]   head_data
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RDOUT = 2'd1;
    localparam logic [1:0] ST_POPB  = 2'd2;

    localparam logic [bdeq_pkg::CNT_W-1:0] FULL_CNT = bdeq_pkg::CNT_W'(bdeq_pkg::DEPTH);

    logic [1:0]                     state_reg, state_next;
    logic [bdeq_pkg::CNT_W-1:0]     count_reg, count_next;
    logic [bdeq_pkg::IDX_W-1:0]     k_reg, k_next;
    logic                           m_valid_reg;
    bdeq_pkg::out_beat_t            m_data_reg;
    bdeq_pkg::out_beat_t            out_next;
    logic                           out_load;
    logic                           out_free;
    logic                           accept;
    logic                           is_full;
    logic                           is_empty;
    logic                           k_at_end;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_valid && s_ready;
    assign is_full  = count_reg == FULL_CNT;
    assign is_empty = count_reg == '0;
    assign k_at_end = bdeq_pkg::CNT_W'(k_reg) == (count_reg - bdeq_pkg::CNT_W'(1));

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        k_next          = k_reg;
        ctl.cmd         = bdeq_pkg::CMD_HOLD;
        ctl.value       = s_data.value;
        out_load        = 1'b0;
        out_next.status = bdeq_pkg::ST_OK;
        out_next.data   = '0;
        out_next.last   = 1'b1;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (s_data.op)
                        bdeq_pkg::OP_PUSH_FRONT, bdeq_pkg::OP_PUSH_BACK: begin
                            out_load = 1'b1;
                            if (is_full) begin
                                out_next.status = bdeq_pkg::ST_OVERFLOW;
                            end else begin
                                ctl.cmd    = (s_data.op == bdeq_pkg::OP_PUSH_FRONT) ?
                                             bdeq_pkg::CMD_SHIFT_R : bdeq_pkg::CMD_APPEND;
                                count_next = count_reg + bdeq_pkg::CNT_W'(1);
                            end
                        end
                        bdeq_pkg::OP_POP_FRONT: begin
                            out_load = 1'b1;
                            if (is_empty) begin
                                out_next.status = bdeq_pkg::ST_UNDERFLOW;
                            end else begin
                                out_next.data = head_data;
                                ctl.cmd       = bdeq_pkg::CMD_SHIFT_L;
                                count_next    = count_reg - bdeq_pkg::CNT_W'(1);
                            end
                        end
                        bdeq_pkg::OP_POP_BACK: begin
                            if (is_empty) begin
                                out_load        = 1'b1;
                                out_next.status = bdeq_pkg::ST_UNDERFLOW;
                            end else begin
                                state_next = ST_POPB;
                                k_next     = '0;
                            end
                        end
                        bdeq_pkg::OP_READ_ALL: begin
                            if (is_empty) begin
                                out_load        = 1'b1;
                                out_next.status = bdeq_pkg::ST_UNDERFLOW;
                            end else begin
                                state_next = ST_RDOUT;
                                k_next     = '0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_RDOUT: begin
                // emit the head and rotate; count rotations restore the order
                if (out_free) begin
                    out_load      = 1'b1;
                    out_next.data = head_data;
                    out_next.last = k_at_end;
                    ctl.cmd       = bdeq_pkg::CMD_ROTATE;
                    k_next        = k_reg + bdeq_pkg::IDX_W'(1);
                    if (k_at_end) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_POPB: begin
                // count-1 rotations bring the back entry to the head
                if (k_at_end) begin
                    if (out_free) begin
                        out_load      = 1'b1;
                        out_next.data = head_data;
                        ctl.cmd       = bdeq_pkg::CMD_SHIFT_L;
                        count_next    = count_reg - bdeq_pkg::CNT_W'(1);
                        state_next    = ST_IDLE;
                    end
                end else begin
                    ctl.cmd = bdeq_pkg::CMD_ROTATE;
                    k_next  = k_reg + bdeq_pkg::IDX_W'(1);
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            k_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            k_reg     <= k_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= out_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL_CNT)
        else $error("entry count beyond depth");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RDOUT || state_reg == ST_POPB) |-> !is_empty)
        else $error("multi-cycle operation on empty queue");

    assert property (@(posedge aclk) disable iff (!aresetn)
        accept && is_full && (s_data.op == bdeq_pkg::OP_PUSH_FRONT ||
        s_data.op == bdeq_pkg::OP_PUSH_BACK) |=> $stable(count_reg))
        else $error("push on full queue changed the count");

    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_IDLE |-> !s_ready)
        else $error("input taken while busy");

    assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> out_free)
        else $error("result register overwritten");

endmodule
`default_nettype wire

// ===== hw/rtl/bounded_double_ended_queue.sv =====
// push, pop front and error results: one beat accepted per cycle while m_ready is high,
// result registered and valid in the next cycle
// pop back: count-1 head rotations through the cell chain, then the result
// read out: one entry a cycle from head cell, rotating the chain, while m_ready is high
// next item is taken once the current one has placed its last result
// synchronous active-low reset empties the chain; entry data is not cleared
`default_nettype none
module bounded_double_ended_queue (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire bdeq_pkg::in_beat_t  s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output bdeq_pkg::out_beat_t      m_data
);

    bdeq_pkg::chain_ctl_t ctl;
    logic signed [31:0]   cell_data [bdeq_pkg::DEPTH];
    logic                 cell_occ  [bdeq_pkg::DEPTH];

    bdeq_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .ctl       (ctl),
        .head_data (cell_data[0])
    );

    for (genvar i = 0; i < bdeq_pkg::DEPTH; i++) begin : g_cell
        logic signed [31:0] left_data;
        logic               left_occ;
        logic signed [31:0] right_data;
        logic               right_occ;

        if (i == 0) begin : g_first
            assign left_data = ctl.value;
            assign left_occ  = 1'b1;
        end else begin : g_mid_l
            assign left_data = cell_data[i-1];
            assign left_occ  = cell_occ[i-1];
        end

        if (i == bdeq_pkg::DEPTH - 1) begin : g_last
            assign right_data = '0;
            assign right_occ  = 1'b0;
        end else begin : g_mid_r
            assign right_data = cell_data[i+1];
            assign right_occ  = cell_occ[i+1];
        end

        bdeq_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctl        (ctl),
            .left_data  (left_data),
            .left_occ   (left_occ),
            .right_data (right_data),
            .right_occ  (right_occ),
            .head_data  (cell_data[0]),
            .data_out   (cell_data[i]),
            .occ_out    (cell_occ[i])
        );
    end

endmodule
`default_nettype wire

// ===== test/tb_bounded_double_ended_queue.sv =====
`timescale 1ns / 100ps
module tb_bounded_double_ended_queue;
    import bdeq_pkg::*;

    // op codes the block has to ignore
    localparam logic [2:0] OP_RSVD_5 = 3'd5;
    localparam logic [2:0] OP_RSVD_6 = 3'd6;
    localparam logic [2:0] OP_RSVD_7 = 3'd7;

    localparam int RUN_ITEMS   = 340;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN_LIMIT = 20_000;
    localparam int TAIL_CYCLES = 200;

    typedef enum {PH_FILL, PH_DRAIN, PH_MIXED} load_phase_t;

    typedef struct {
        in_beat_t  beat;
        bit        typed;
        out_beat_t want;
    } stim_row_t;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_beat_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_beat_t m_data;

    // queue image kept alongside the block
    logic signed [31:0] ring_mem [DEPTH];
    logic [IDX_W-1:0]   head_idx = '0;
    logic [CNT_W-1:0]   fill_cnt = '0;

    out_beat_t op_results[$];
    out_beat_t pending_results[$];
    stim_row_t dir_rows[$];

    int fail_count = 0;
    int cycle_cnt  = 0;
    int burst_left = 0;

    bounded_double_ended_queue u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic out_beat_t make_result(logic [1:0] status, logic signed [31:0] data,
                                              logic last);
        out_beat_t r;
        r.status = status;
        r.data   = data;
        r.last   = last;
        return r;
    endfunction

    function automatic logic [IDX_W-1:0] slot(int offset);
        return IDX_W'((int'(head_idx) + offset) % DEPTH);
    endfunction

    // applies one op to the queue image and collects the beats it causes
    function automatic void deque_apply(input in_beat_t beat);
        logic signed [31:0] taken;
        op_results.delete();
        case (beat.op)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
                if (fill_cnt >= DEPTH) begin
                    op_results.push_back(make_result(ST_OVERFLOW, '0, 1'b1));
                end else begin
                    if (beat.op == OP_PUSH_FRONT) begin
                        head_idx = slot(DEPTH - 1);
                        ring_mem[head_idx] = beat.value;
                    end else begin
                        ring_mem[slot(int'(fill_cnt))] = beat.value;
                    end
                    fill_cnt = fill_cnt + 1'b1;
                    op_results.push_back(make_result(ST_OK, '0, 1'b1));
                end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
                if (fill_cnt == 0) begin
                    op_results.push_back(make_result(ST_UNDERFLOW, '0, 1'b1));
                end else begin
                    if (beat.op == OP_POP_FRONT) begin
                        taken = ring_mem[slot(0)];
                        head_idx = slot(1);
                    end else begin
                        taken = ring_mem[slot(int'(fill_cnt) - 1)];
                    end
                    fill_cnt = fill_cnt - 1'b1;
                    op_results.push_back(make_result(ST_OK, taken, 1'b1));
                end
            end
            OP_READ_ALL: begin
                if (fill_cnt == 0) begin
                    op_results.push_back(make_result(ST_UNDERFLOW, '0, 1'b1));
                end else begin
                    for (int k = 0; k < fill_cnt; k++) begin
                        op_results.push_back(make_result(ST_OK, ring_mem[slot(k)],
                                                         k == fill_cnt - 1));
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // typed rows carry one result: status given, data zero, last set
    function automatic void add_row(logic [2:0] op, logic [31:0] value, bit typed,
                                    logic [1:0] status);
        stim_row_t row;
        row.beat.op    = op;
        row.beat.value = value;
        row.typed      = typed;
        row.want       = make_result(status, '0, 1'b1);
        dir_rows.push_back(row);
    endfunction

    task automatic send_beat(input in_beat_t beat, input bit typed, input out_beat_t want);
        s_data  <= beat;
        s_valid <= 1'b1;
        do @(posedge aclk); while (s_ready !== 1'b1);
        deque_apply(beat);
        if (typed) begin
            pending_results.push_back(want);
        end else begin
            foreach (op_results[k]) pending_results.push_back(op_results[k]);
        end
    endtask

    task automatic idle_between();
        int gap;
        burst_left = burst_left - 1;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap = $urandom_range(0, 5);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    task automatic pause_until_drained();
        int waited;
        waited = 0;
        s_valid <= 1'b0;
        while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        if (pending_results.size() != 0) begin
            $error("%0d expected result beats never arrived", pending_results.size());
            fail_count++;
            pending_results.delete();
        end
    endtask

    // receiver stall pattern plus run limit
    always @(posedge aclk) begin
        cycle_cnt = cycle_cnt + 1;
        case ((cycle_cnt / 97) % 4)
            0: m_ready <= 1'b1;
            1: m_ready <= 1'($urandom_range(0, 1));
            2: m_ready <= ($urandom_range(0, 7) != 0);
            default: m_ready <= (cycle_cnt % 5 != 0);
        endcase
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge aclk) begin
        out_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result beat: status %0d data %0d last %0d",
                       m_data.status, m_data.data, m_data.last);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_data.status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, m_data.status);
                    fail_count++;
                end
                if (m_data.data !== want.data) begin
                    $error("data: expected %0d, actual %0d", want.data, m_data.data);
                    fail_count++;
                end
                if (m_data.last !== want.last) begin
                    $error("last: expected %0d, actual %0d", want.last, m_data.last);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        in_beat_t    beat;
        load_phase_t phase;
        int          counted;
        int          roll;
        int          push_pct;
        int          mixed_left;

        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        m_ready = 1'b0;

        add_row(OP_POP_FRONT,  32'h0000_0000, 1'b1, ST_UNDERFLOW);
        add_row(OP_POP_BACK,   32'h5A5A_5A5A, 1'b1, ST_UNDERFLOW);
        add_row(OP_READ_ALL,   32'hFFFF_FFFF, 1'b1, ST_UNDERFLOW);
        add_row(OP_RSVD_5,     32'h0000_0000, 1'b0, ST_OK);
        add_row(OP_PUSH_FRONT, 32'h7FFF_FFFF, 1'b1, ST_OK);
        add_row(OP_PUSH_BACK,  32'h8000_0000, 1'b1, ST_OK);
        add_row(OP_PUSH_FRONT, 32'hFFFF_FFFF, 1'b1, ST_OK);
        add_row(OP_PUSH_BACK,  32'h0000_0000, 1'b1, ST_OK);
        add_row(OP_READ_ALL,   32'h0000_0000, 1'b0, ST_OK);
        add_row(OP_RSVD_6,     32'h1234_5678, 1'b0, ST_OK);
        add_row(OP_POP_BACK,   32'h0000_0000, 1'b0, ST_OK);
        add_row(OP_POP_FRONT,  32'h0000_0000, 1'b0, ST_OK);
        add_row(OP_PUSH_BACK,  32'h0000_0001, 1'b1, ST_OK);
        add_row(OP_READ_ALL,   32'h0000_0000, 1'b0, ST_OK);
        add_row(OP_RSVD_7,     32'hFFFF_FFFF, 1'b0, ST_OK);
        add_row(OP_POP_FRONT,  32'h0000_0000, 1'b0, ST_OK);
        add_row(OP_POP_BACK,   32'h0000_0000, 1'b0, ST_OK);
        add_row(OP_POP_FRONT,  32'h0000_0000, 1'b0, ST_OK);
        add_row(OP_POP_BACK,   32'h0000_0000, 1'b1, ST_UNDERFLOW);
        add_row(OP_READ_ALL,   32'h0000_0000, 1'b1, ST_UNDERFLOW);
        add_row(OP_PUSH_FRONT, 32'hAAAA_AAAA, 1'b1, ST_OK);
        add_row(OP_POP_FRONT,  32'h0000_0000, 1'b0, ST_OK);

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i]) begin
            send_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].want);
            idle_between();
        end
        pause_until_drained();

        // fill to full and overflow, drain to empty and underflow, then mix and start over
        phase = PH_FILL;
        mixed_left = 0;
        counted = 0;
        while (counted < RUN_ITEMS) begin
            if (counted == RUN_ITEMS / 2) pause_until_drained();
            beat.value = $urandom;
            roll = $urandom_range(0, 99);
            if (roll < 3) begin
                beat.op = 3'($urandom_range(OP_RSVD_5, OP_RSVD_7));
            end else if (roll < 8) begin
                beat.op = OP_READ_ALL;
            end else begin
                push_pct = (phase == PH_FILL) ? 85 : (phase == PH_DRAIN) ? 15 : 50;
                if ($urandom_range(0, 99) < push_pct) begin
                    beat.op = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
                end else begin
                    beat.op = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
                end
            end
            send_beat(beat, 1'b0, '0);
            if (roll >= 3) counted++;
            case (phase)
                PH_FILL: begin
                    if (fill_cnt == DEPTH && $urandom_range(0, 3) == 0) phase = PH_DRAIN;
                end
                PH_DRAIN: begin
                    if (fill_cnt == 0 && $urandom_range(0, 3) == 0) begin
                        phase = PH_MIXED;
                        mixed_left = 40;
                    end
                end
                default: begin
                    mixed_left = mixed_left - 1;
                    if (mixed_left <= 0) phase = PH_FILL;
                end
            endcase
            idle_between();
        end

        pause_until_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
